### rtl/assert_macros.svh
// assertion macros shared by the rtl of the held key table
// no dependencies; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HKT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");
`define HKT_ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("%m: check failed");
`else
`define HKT_ASSERT(label, clk, rst, prop)
`define HKT_ASSERT_IMPL(label, clk, rst, cond, prop)
`endif
`endif

### rtl/hkt_pkg.sv
// types and constants of the held key table
// no dependencies; used by the interfaces, the cell and the top level
package hkt_pkg;

  localparam int CAPACITY = 15;
  localparam int CODE_W   = 9;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_DOWN  = 2'd1,
    CMD_UP    = 2'd2,
    CMD_QUERY = 2'd3
  } hkt_cmd_t;

  // broadcast to every cell for one transaction
  typedef struct packed {
    logic              tick;
    logic              down;
    logic              up;
    logic [CODE_W-1:0] code;
  } hkt_op_t;

  // running match status passed from cell to cell
  typedef struct packed {
    logic hit_seen;
    logic new_seen;
  } hkt_link_t;

  typedef struct packed {
    logic              valid;
    logic              flag;
    logic [CODE_W-1:0] code;
  } hkt_entry_t;

endpackage

### rtl/hkt_ifs.sv
// request and response channel interfaces of the held key table
// depends on hkt_pkg for the field widths
interface hkt_req_if;
  import hkt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [CODE_W-1:0] scancode;
  logic              typing_active;
  modport source (output valid, command, scancode, typing_active, input ready);
  modport sink (input valid, command, scancode, typing_active, output ready);
endinterface

interface hkt_rsp_if;
  logic       valid;
  logic       ready;
  logic       key_held;
  logic       key_new;
  logic [3:0] held_count;
  logic       table_full;
  modport source (output valid, key_held, key_new, held_count, table_full, input ready);
  modport sink (input valid, key_held, key_new, held_count, table_full, output ready);
endinterface

### rtl/hkt_cell.sv
// one entry of the held key list: code, newly-pressed flag and valid bit
// depends on hkt_pkg; chained by held_key_table
module hkt_cell (
  input  logic               clk,
  input  logic               rst,
  input  hkt_pkg::hkt_op_t   op,
  input  hkt_pkg::hkt_link_t link_in,
  output hkt_pkg::hkt_link_t link_out,
  input  logic               prev_valid,
  input  hkt_pkg::hkt_entry_t nb,
  output hkt_pkg::hkt_entry_t entry
);
  import hkt_pkg::*;

  logic              valid;
  logic              flag;
  logic [CODE_W-1:0] code;
  logic              hit;
  logic              shift;
  logic              load;

  assign hit   = valid && (code == op.code);
  // on removal every cell at or after the match takes its neighbor's entry
  assign shift = op.up && (link_in.hit_seen || hit);
  // first empty cell takes an appended key
  assign load  = op.down && !valid && prev_valid;

  assign link_out.hit_seen = link_in.hit_seen || hit;
  assign link_out.new_seen = link_in.new_seen || (hit && flag);

  assign entry.valid = valid;
  assign entry.flag  = flag;
  assign entry.code  = code;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      flag  <= 1'b0;
    end else if (shift) begin
      valid <= nb.valid;
      flag  <= nb.flag;
    end else if (load) begin
      valid <= 1'b1;
      flag  <= 1'b1;
    end else if (op.tick) begin
      flag <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      code <= nb.code;
    end else if (load) begin
      code <= op.code;
    end
  end

endmodule

### rtl/held_key_table.sv
// held key table top level: a chain of hkt_cell entries and the result register
// depends on hkt_pkg, hkt_ifs and assert_macros.svh
//
// Keeps the list of held keyboard scancodes in order of arrival, one cell per
// entry, each with a newly-pressed flag.
// req carries command, scancode and typing_active; a transaction is taken
// when valid and ready are both high. rsp returns exactly one result per
// request: key_held, key_new, held_count and table_full after the operation.
// The result is registered: it sits in rsp on the cycle after the request
// is taken. One request per cycle is sustained while rsp.ready is high;
// all cells compare the code in parallel and the match status ripples down
// the chain in the same cycle, so a key-up closes the gap in that cycle too.
// req.ready is high while the result register is empty or being drained, so
// a stalled receiver holds the result and blocks new requests until taken.
// Reset (rst, synchronous) empties the list, clears every flag and marks the
// result register empty; no clearing pass is needed.
`include "assert_macros.svh"
module held_key_table (
  input  logic  clk,
  input  logic  rst,
  hkt_req_if.sink   req,
  hkt_rsp_if.source rsp
);
  import hkt_pkg::*;

  hkt_op_t              op;
  hkt_link_t            links [CAPACITY+1];
  hkt_entry_t           cells [CAPACITY];
  logic [CAPACITY-1:0]  valid_vec;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [CNT_W+3:0]     count_wide;
  logic                 in_acc;
  logic                 full;
  logic                 any_hit;
  logic                 hit_new;
  logic                 appended;
  logic                 held_next;
  logic                 new_next;
  hkt_cmd_t             cmd;

  logic                 out_valid;
  logic                 key_held;
  logic                 key_new;
  logic [3:0]           held_count;
  logic                 table_full;

  assign in_acc    = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;
  assign cmd       = hkt_cmd_t'(req.command);

  assign any_hit = links[CAPACITY].hit_seen;
  assign hit_new = links[CAPACITY].new_seen;
  assign full    = (count == CNT_W'(CAPACITY));

  assign op.tick = in_acc && (cmd == CMD_TICK);
  assign op.down = in_acc && (cmd == CMD_DOWN) && !any_hit;
  assign op.up   = in_acc && (cmd == CMD_UP);
  assign op.code = req.scancode;

  assign links[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    hkt_entry_t nb;
    logic       prev_valid;
    if (i == CAPACITY - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = cells[i+1];
    end
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = cells[i-1].valid;
    end
    hkt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .link_in    (links[i]),
      .link_out   (links[i+1]),
      .prev_valid (prev_valid),
      .nb         (nb),
      .entry      (cells[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  assign appended = op.down && !full;

  always_comb begin
    count_next = count;
    if (appended) begin
      count_next = count + 1'b1;
    end else if (op.up && any_hit) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    held_next = 1'b0;
    new_next  = 1'b0;
    case (cmd)
      CMD_TICK: begin
        held_next = any_hit;
      end
      CMD_DOWN: begin
        held_next = any_hit || !full;
        new_next  = any_hit ? hit_new : !full;
      end
      CMD_UP: begin
        held_next = 1'b0;
      end
      CMD_QUERY: begin
        held_next = any_hit && !req.typing_active;
        new_next  = hit_new && !req.typing_active;
      end
      default: begin
        held_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_acc) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign count_wide = {4'b0000, count_next};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_held   <= held_next;
      key_new    <= new_next;
      held_count <= count_wide[3:0];
      table_full <= (count_next == CNT_W'(CAPACITY));
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.key_held   = key_held;
  assign rsp.key_new    = key_new;
  assign rsp.held_count = held_count;
  assign rsp.table_full = table_full;

  // the fill count always equals the number of valid cells
  `HKT_ASSERT(a_count_matches, clk, rst, count == CNT_W'($countones(valid_vec)))
  // valid cells form an unbroken run from the head of the chain
  `HKT_ASSERT(a_compact, clk, rst, (valid_vec & (valid_vec + 1'b1)) == '0)
  // a key-down for an absent code with room grows the list by one
  `HKT_ASSERT_IMPL(a_down_grows, clk, rst, appended, count == $past(count) + 1'b1)
  // removal of a listed key shrinks the list by one
  `HKT_ASSERT_IMPL(a_up_shrinks, clk, rst, op.up && any_hit,
    count == $past(count) - 1'b1)

endmodule
